### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on clk_i, with and without the reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define HTFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HTFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types, constants and functions of the sensor frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  // frame byte positions
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUMI_SPAN   = 14'd10000;

  localparam int unsigned TEMP_PROD_W = 31;
  localparam int unsigned HUMI_PROD_W = 30;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUMI_CRC = 2'd2
  } htfd_status_e;

  typedef struct packed {
    logic temp_crc_bad;
    logic humi_crc_bad;
  } htfd_chk_t;

  // crc-8, msb first, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 17501 * 65536
  function automatic logic [14:0] div_full_scale(input logic [TEMP_PROD_W-1:0] x);
    logic [14:0] q1;
    logic [16:0] r;
    q1 = x[TEMP_PROD_W-1:16];
    r  = {1'b0, x[15:0]} + {2'b00, q1};
    if (r >= {1'b0, FULL_SCALE}) begin
      return q1 + 15'd1;
    end
    return q1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/htfd_convert.sv
// ----------------------------------------------------------------------------
// htfd_convert
// crc status priority and fixed-point scaling of the raw products
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_convert (
  input  logic [htfd_pkg::TEMP_PROD_W-1:0] temp_prod_i,
  input  logic [htfd_pkg::HUMI_PROD_W-1:0] humi_prod_i,
  input  htfd_pkg::htfd_chk_t              chk_i,
  output htfd_pkg::htfd_status_e           status_o,
  output logic signed [14:0]               temp_centi_o,
  output logic [13:0]                      humi_centi_o
);
  import htfd_pkg::*;

  logic [14:0] temp_q;
  logic [14:0] humi_q;

  assign temp_q = div_full_scale(temp_prod_i);
  assign humi_q = div_full_scale({1'b0, humi_prod_i});

  always_comb begin
    priority if (chk_i.temp_crc_bad) begin
      status_o = ST_TEMP_CRC;
    end else if (chk_i.humi_crc_bad) begin
      status_o = ST_HUMI_CRC;
    end else begin
      status_o = ST_OK;
    end
  end

  always_comb begin
    if (status_o == ST_OK) begin
      temp_centi_o = $signed(temp_q - TEMP_OFFSET);
      humi_centi_o = humi_q[13:0];
    end else begin
      temp_centi_o = '0;
      humi_centi_o = '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// decodes the six-byte temperature/humidity frame of a sensor into a status
// and scaled readings
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, in the order temperature high,
// low, crc, humidity high, low, crc; tuser bit 0 marks the first byte of a
// frame and restarts decoding, but is optional between frames that follow
// each other. Each crc is crc-8 (poly 0x31, init 0xff) over its word. The
// word products are formed when the low byte arrives, so the result (status
// in tuser, temperature in 0.01 degC and humidity in 0.01 %RH in tdata) is
// loaded into the output register on the clock edge that takes the sixth byte.
// Status 1 flags a bad temperature crc and wins over status 2, a bad
// humidity crc; on either error both readings are zero. While a result waits
// and the output side holds off, the input side stalls; with the output side
// ready the sustained rate is one byte per clock.
`default_nettype none

`include "assert_macros.svh"

module humidity_temp_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import htfd_pkg::*;

  logic       s_acc;
  logic [2:0] pos_eff;
  logic [7:0] crc_next;

  logic [2:0]             pos_q,       pos_d;
  logic [7:0]             crc_q,       crc_d;
  logic [7:0]             t_hi_q,      t_hi_d;
  logic [7:0]             h_hi_q,      h_hi_d;
  logic [TEMP_PROD_W-1:0] t_prod_q,    t_prod_d;
  logic [HUMI_PROD_W-1:0] h_prod_q,    h_prod_d;
  logic                   t_bad_q,     t_bad_d;
  logic                   m_valid_q,   m_valid_d;
  htfd_status_e           status_q,    status_d;
  logic signed [14:0]     temp_q,      temp_d;
  logic [13:0]            humi_q,      humi_d;

  htfd_chk_t    chk;
  htfd_status_e cv_status;
  logic signed [14:0] cv_temp;
  logic [13:0]  cv_humi;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign pos_eff  = (s_axis_tuser[0] || (pos_q > POS_H_CRC)) ? POS_T_HI : pos_q;
  assign crc_next = crc8_update(((pos_eff == POS_T_HI) || (pos_eff == POS_H_HI)) ?
                                CRC_INIT : crc_q, s_axis_tdata);

  assign chk.temp_crc_bad = t_bad_q;
  assign chk.humi_crc_bad = (crc_q != s_axis_tdata);

  htfd_convert u_convert (
    .temp_prod_i  (t_prod_q),
    .humi_prod_i  (h_prod_q),
    .chk_i        (chk),
    .status_o     (cv_status),
    .temp_centi_o (cv_temp),
    .humi_centi_o (cv_humi)
  );

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    t_hi_d    = t_hi_q;
    h_hi_d    = h_hi_q;
    t_prod_d  = t_prod_q;
    h_prod_d  = h_prod_q;
    t_bad_d   = t_bad_q;
    status_d  = status_q;
    temp_d    = temp_q;
    humi_d    = humi_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (s_acc) begin
      pos_d = pos_eff + 3'd1;
      unique case (pos_eff)
        POS_T_HI: begin
          crc_d  = crc_next;
          t_hi_d = s_axis_tdata;
        end
        POS_T_LO: begin
          crc_d    = crc_next;
          t_prod_d = TEMP_PROD_W'(TEMP_SPAN) * TEMP_PROD_W'({t_hi_q, s_axis_tdata});
        end
        POS_T_CRC: begin
          t_bad_d = (crc_q != s_axis_tdata);
          crc_d   = CRC_INIT;
        end
        POS_H_HI: begin
          crc_d  = crc_next;
          h_hi_d = s_axis_tdata;
        end
        POS_H_LO: begin
          crc_d    = crc_next;
          h_prod_d = HUMI_PROD_W'(HUMI_SPAN) * HUMI_PROD_W'({h_hi_q, s_axis_tdata});
        end
        POS_H_CRC: begin
          crc_d     = CRC_INIT;
          t_bad_d   = 1'b0;
          pos_d     = POS_T_HI;
          status_d  = cv_status;
          temp_d    = cv_temp;
          humi_d    = cv_humi;
          m_valid_d = 1'b1;
        end
        default: begin
          pos_d = POS_T_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_T_HI;
      crc_q     <= CRC_INIT;
      t_bad_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      t_bad_q   <= t_bad_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_hi_q   <= t_hi_d;
    h_hi_q   <= h_hi_d;
    t_prod_q <= t_prod_d;
    h_prod_q <= h_prod_d;
    status_q <= status_d;
    temp_q   <= temp_d;
    humi_q   <= humi_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, humi_q, temp_q};

  `HTFD_ASSERT_ALWAYS(a_pos_range, pos_q <= POS_H_CRC, "byte position out of frame")
  `HTFD_ASSERT(a_result_after_crc,
    $rose(m_valid_q) |-> $past(s_acc && (pos_eff == POS_H_CRC)),
    "result without a closing crc byte")
  `HTFD_ASSERT(a_error_zero,
    m_valid_q && (status_q != ST_OK) |-> (temp_q == '0) && (humi_q == '0),
    "nonzero reading on crc error")
  `HTFD_ASSERT(a_ok_range,
    m_valid_q && (status_q == ST_OK) |->
      (temp_q >= -15'sd4500) && (temp_q <= 15'sd13000) && (humi_q <= 14'd10000),
    "reading out of range")

endmodule

`default_nettype wire

### sim/htfd_reading_checker.sv
// ----------------------------------------------------------------------------
// htfd_reading_checker
// watches both streams of the sensor frame decoder, predicts each reading and
// compares it with what the decoder puts out
// ----------------------------------------------------------------------------
// Every accepted input word moves a frame tracker of its own. After the sixth
// byte of a frame the tracker queues one expected reading: status, scaled
// temperature and scaled humidity. Each accepted output word is compared
// field by field with the oldest queued reading. Any difference, or an output
// with nothing queued, goes to the report task and into the mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package htfd_tb_pkg;

  localparam logic [7:0] CRC8_POLY = 8'h31;
  localparam logic [7:0] CRC8_SEED = 8'hFF;

  localparam longint unsigned RAW_FULL_SCALE = 65535;
  localparam longint unsigned TEMP_SPAN_C    = 17500;
  localparam logic [14:0]     TEMP_BIAS_C    = 15'd4500;
  localparam longint unsigned HUMI_SPAN_C    = 10000;

  // crc-8 over one 16-bit measurement word, msb first
  function automatic logic [7:0] crc8_word(input logic [15:0] w);
    logic [7:0] acc;
    logic       fb;
    acc = CRC8_SEED;
    for (int i = 15; i >= 0; i--) begin
      fb  = acc[7] ^ w[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
    end
    return acc;
  endfunction

endpackage

module htfd_reading_checker
  import htfd_pkg::*;
  import htfd_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser_i,   // [0] frame_start
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [14:0] temperature_centi, [28:15] humidity_centi
  input  logic [1:0]  m_tuser_i,   // [1:0] status
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned readings_o
);

  typedef struct packed {
    htfd_status_e status;
    logic [14:0]  temp_centi;
    logic [13:0]  humi_centi;
  } reading_t;

  reading_t    readings_due[$];
  logic [2:0]  frame_pos = POS_T_HI;
  logic [15:0] temp_raw  = '0;
  logic [15:0] humi_raw  = '0;
  logic        temp_bad  = 1'b0;

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
    readings_o     = 0;
  end

  task automatic flag_mismatch(input string what);
    mismatch_cnt_o++;
    $display("%0t: mismatch on reading %0d: %s", $realtime, readings_o, what);
  endtask

  task automatic decode_frame_byte(input logic [7:0] b, input logic sop);
    logic [2:0]      pos;
    reading_t        r;
    longint unsigned t_scaled;
    longint unsigned h_scaled;
    pos = (sop || frame_pos > POS_H_CRC) ? POS_T_HI : frame_pos;
    frame_pos = pos + 3'd1;
    case (pos)
      POS_T_HI:  temp_raw[15:8] = b;
      POS_T_LO:  temp_raw[7:0]  = b;
      POS_T_CRC: temp_bad       = (crc8_word(temp_raw) != b);
      POS_H_HI:  humi_raw[15:8] = b;
      POS_H_LO:  humi_raw[7:0]  = b;
      default: begin
        r = '0;
        if (temp_bad) begin
          r.status = ST_TEMP_CRC;
        end else if (crc8_word(humi_raw) != b) begin
          r.status = ST_HUMI_CRC;
        end else begin
          r.status     = ST_OK;
          t_scaled     = (TEMP_SPAN_C * longint'(temp_raw)) / RAW_FULL_SCALE;
          h_scaled     = (HUMI_SPAN_C * longint'(humi_raw)) / RAW_FULL_SCALE;
          r.temp_centi = 15'(t_scaled) - TEMP_BIAS_C;
          r.humi_centi = h_scaled[13:0];
        end
        readings_due.push_back(r);
        temp_bad  = 1'b0;
        frame_pos = POS_T_HI;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_streams
    reading_t want;
    if (!rst_ni) begin
      frame_pos = POS_T_HI;
      temp_raw  = '0;
      humi_raw  = '0;
      temp_bad  = 1'b0;
      readings_due.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        readings_o++;
        if (readings_due.size() == 0) begin
          flag_mismatch("reading with none expected");
        end else begin
          want = readings_due.pop_front();
          if (m_tuser_i != want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d", m_tuser_i, want.status));
          end
          if (m_tdata_i[14:0] != want.temp_centi) begin
            flag_mismatch($sformatf("temperature %0d, expected %0d",
                                    $signed(m_tdata_i[14:0]), $signed(want.temp_centi)));
          end
          if (m_tdata_i[28:15] != want.humi_centi) begin
            flag_mismatch($sformatf("humidity %0d, expected %0d",
                                    m_tdata_i[28:15], want.humi_centi));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_frame_byte(s_tdata_i, s_tuser_i[0]);
      end
    end
    pending_o = readings_due.size();
  end

endmodule

### sim/tb_humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder
// stimulus and verdict for the sensor frame decoder
// ----------------------------------------------------------------------------
// Feeds measurement frames byte by byte: a few hand-built frames at the scale
// limits, with both crcs bad and with a bad humidity crc, then random
// with good or corrupted crcs, mixed with partial frames cut short by a new
// frame start. Both stream sides pause in random bursts, the output side
// once for a long stretch so the decoder backs up its input. The checker
// beside the decoder does all comparing; this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_humidity_temp_frame_decoder;
  import htfd_tb_pkg::*;

  localparam int unsigned BYTE_TARGET  = 650;
  localparam int unsigned QUIET_FROM   = 560;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 250000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [0:0]  s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [14:0] temperature_centi, [28:15] humidity_centi
  logic [1:0]  m_axis_tuser;   // [1:0] status

  int unsigned mismatches;
  int unsigned pending;
  int unsigned readings;
  int unsigned cycle_cnt  = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned bad_frames = 0;
  int unsigned cut_frames = 0;
  logic        quiet     = 1'b0;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;

  humidity_temp_frame_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  htfd_reading_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .readings_o     (readings)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings still due", cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output side: random pauses, one long hold once asked
  initial begin : reading_sink
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic sop);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sop;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic put_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                           input logic t_err, input logic h_err, input logic sop);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = crc8_word(t_raw);
    h_crc = crc8_word(h_raw);
    if (t_err) t_crc = t_crc ^ 8'($urandom_range(1, 255));
    if (h_err) h_crc = h_crc ^ 8'($urandom_range(1, 255));
    put_byte(t_raw[15:8], sop);
    put_byte(t_raw[7:0], 1'b0);
    put_byte(t_crc, 1'b0);
    put_byte(h_raw[15:8], 1'b0);
    put_byte(h_raw[7:0], 1'b0);
    put_byte(h_crc, 1'b0);
    frames_sent++;
    if (t_err || h_err) bad_frames++;
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  initial begin : frame_source
    int unsigned roll;
    int unsigned cut_len;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scale limits, unmarked frame, cut frame, both crcs bad, humidity crc bad
    put_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    put_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    put_byte(8'h5A, 1'b1);
    put_byte(8'hA5, 1'b0);
    cut_frames++;
    put_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
    put_frame(16'h1234, 16'hFEDC, 1'b0, 1'b1, 1'b0);

    hold_go = 1'b1;
    while (bytes_sent < BYTE_TARGET) begin
      quiet = (bytes_sent >= QUIET_FROM);
      roll  = $urandom_range(0, 99);
      if (roll < 10) begin
        cut_len = $urandom_range(1, 5);
        repeat (cut_len) put_byte(8'($urandom), 1'($urandom));
        cut_frames++;
        put_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1);
      end else begin
        put_frame(pick_word(), pick_word(), roll < 22 || roll >= 95,
                  (roll >= 22 && roll < 36) || roll >= 95, 1'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d bytes: %0d frames, %0d with corrupted crcs, %0d cut short",
             bytes_sent, frames_sent, bad_frames, cut_frames);
    $display("%0d readings compared, %0d mismatches, long output hold of %0d cycles",
             readings, mismatches, HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
